### rtl/core/gdfp_pkg.sv
// gdfp_pkg: shared constants, codes and controller/datapath interface types
// for the group delay from phase block. no dependencies.
`timescale 1ns / 1ps

package gdfp_pkg;

  // 2*pi*c scaled so that numerator / (lambda in 1/16 nm) gives Q8.24 rad/fs
  localparam logic [39:0] FREQ_NUM = 40'd505638867416;

  // pi and 2*pi in Q5.26, sign-extended to the unwrap width
  localparam logic signed [33:0] PHASE_PI  = 34'sd210828714;
  localparam logic signed [33:0] PHASE_2PI = 34'sd421657428;

  // saturation magnitude of the internal fixed-point values (2^60)
  localparam logic [60:0] SAT_MAG = {1'b1, 60'd0};

  // divider geometry
  localparam int DIV_W = 86;
  localparam int DEN_W = 33;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd2;

  // configuration register indexes
  localparam logic REG_OUTPUT_KIND = 1'b0;
  localparam logic REG_UNWRAP      = 1'b1;

  // what the shared divider is working on
  typedef enum logic [1:0] {
    DIV_FREQ = 2'd0,
    DIV_F01  = 2'd1,
    DIV_F12  = 2'd2,
    DIV_F012 = 2'd3
  } div_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     setup;
    logic     mul_start;
    logic [1:0] pt;
    logic     emit;
    logic     emit_short;
    logic     emit_eor;
    logic     update;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic zero_den;
    logic out_free;
    logic last_pt;
    logic output_kind;
  } sts_t;

endpackage

### rtl/core/gdfp_div.sv
// gdfp_div: restoring divider, one quotient bit per cycle, left-aligned
// dividend with a run-time bit count. depends on gdfp_pkg.
`timescale 1ns / 1ps

module gdfp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gdfp_pkg::DIV_W-1:0]    dividend,
  input  logic [6:0]                    nbits,
  input  logic [gdfp_pkg::DEN_W-1:0]    divisor,
  output logic                          done,
  output logic [gdfp_pkg::DIV_W-1:0]    quot,
  output logic                          round_up
);

  logic [gdfp_pkg::DIV_W-1:0] shreg;
  logic [gdfp_pkg::DEN_W-1:0] rem;
  logic [gdfp_pkg::DEN_W-1:0] den;
  logic [6:0]                 cnt;
  logic                       busy;
  logic [gdfp_pkg::DEN_W:0]   trial;
  logic [gdfp_pkg::DEN_W+1:0] diff;
  logic                       fit;

  // trial subtraction of the divisor from the shifted remainder
  assign trial = {rem, shreg[gdfp_pkg::DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den};
  assign fit   = ~diff[gdfp_pkg::DEN_W+1];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nbits;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      den   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[gdfp_pkg::DIV_W-2:0], fit};
      rem   <= fit ? diff[gdfp_pkg::DEN_W-1:0] : trial[gdfp_pkg::DEN_W-1:0];
    end
  end

  assign quot     = shreg;
  // round half up on the magnitude: twice the remainder against the divisor
  assign round_up = ({rem, 1'b0} >= {1'b0, den});

endmodule

### rtl/core/gdfp_mul.sv
// gdfp_mul: 61 x 34 bit unsigned multiplier, four 16-bit partial products
// accumulated in turn. no dependencies.
`timescale 1ns / 1ps

module gdfp_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [60:0] a,
  input  logic [33:0] b,
  output logic        done,
  output logic [97:0] prod
);

  logic [63:0] a_sh;
  logic [33:0] bb;
  logic [97:0] acc;
  logic [2:0]  cnt;
  logic        busy;
  logic [49:0] pp;

  assign pp = a_sh[63:48] * bb;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd4;
      end else if (busy) begin
        cnt <= cnt - 3'd1;
        if (cnt == 3'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // top chunk first, shift and add
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= {3'b000, a};
      bb   <= b;
      acc  <= '0;
    end else if (busy) begin
      a_sh <= {a_sh[47:0], 16'd0};
      acc  <= {acc[81:0], 16'd0} + {48'd0, pp};
    end
  end

  assign prod = acc;

endmodule

### rtl/core/gdfp_dp.sv
// gdfp_dp: datapath - point registers, phase unwrap, divided differences,
// result evaluation and output register. depends on gdfp_pkg, gdfp_div, gdfp_mul.
`timescale 1ns / 1ps

module gdfp_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_data,
  input  logic [19:0]          wavelength,
  input  logic [31:0]          phase_in,
  input  logic                 last_point,
  input  gdfp_pkg::cmd_t       cmd,
  output gdfp_pkg::sts_t       sts,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);

  // fixed-point to Q16.16 with 12-bit rounding shift and saturation
  function automatic logic [31:0] to_q16(input logic signed [62:0] v);
    logic [62:0] vm;
    logic [62:0] s;
    logic [50:0] m;
    vm = v[62] ? 63'(-v) : 63'(v);
    s  = vm + 63'd2048;
    m  = s[62:12];
    if (v[62]) begin
      if (m >= 51'h80000000) return 32'h80000000;
      return ~m[31:0] + 32'd1;
    end
    if (m > 51'h7FFFFFFF) return 32'h7FFFFFFF;
    return m[31:0];
  endfunction

  logic [19:0]  wl_r;
  logic [31:0]  ph_r;
  logic         last_r;
  logic [31:0]  w_r;
  logic [31:0]  freq_older, freq_newer, phase_older, phase_newer;
  logic         kind_r, unwrap_r;
  logic signed [33:0] y0, y1, y2;
  logic signed [61:0] f01, f12, f012, t_r;
  logic         mul_neg;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_r   <= 1'b0;
      unwrap_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        gdfp_pkg::REG_OUTPUT_KIND: kind_r   <= cfg_data;
        gdfp_pkg::REG_UNWRAP:      unwrap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase unwrap of the window, each step against the adjusted neighbour
  logic signed [33:0] y0s, y1s, y2s, d1, d2, y1u, y2u;
  always_comb begin
    y0s = $signed({{2{phase_older[31]}}, phase_older});
    y1s = $signed({{2{phase_newer[31]}}, phase_newer});
    y2s = $signed({{2{ph_r[31]}}, ph_r});
    d1  = y1s - y0s;
    if (unwrap_r && d1 > gdfp_pkg::PHASE_PI)       y1u = y1s - gdfp_pkg::PHASE_2PI;
    else if (unwrap_r && d1 < -gdfp_pkg::PHASE_PI) y1u = y1s + gdfp_pkg::PHASE_2PI;
    else                                            y1u = y1s;
    d2  = y2s - y1u;
    if (unwrap_r && d2 > gdfp_pkg::PHASE_PI)       y2u = y2s - gdfp_pkg::PHASE_2PI;
    else if (unwrap_r && d2 < -gdfp_pkg::PHASE_PI) y2u = y2s + gdfp_pkg::PHASE_2PI;
    else                                            y2u = y2s;
  end

  // differences and magnitudes for the divider
  logic signed [34:0] num01, num12;
  logic signed [33:0] den01, den12, den02;
  logic signed [62:0] num012;
  logic [33:0] n01m, n12m;
  logic [61:0] n012m;
  logic [32:0] d01m, d12m, d02m;
  always_comb begin
    num01  = $signed({y1[33], y1}) - $signed({y0[33], y0});
    num12  = $signed({y2[33], y2}) - $signed({y1[33], y1});
    den01  = $signed({2'b00, freq_newer}) - $signed({2'b00, freq_older});
    den12  = $signed({2'b00, w_r}) - $signed({2'b00, freq_newer});
    den02  = $signed({2'b00, w_r}) - $signed({2'b00, freq_older});
    num012 = $signed({f12[61], f12}) - $signed({f01[61], f01});
    n01m   = num01[34] ? 34'(-num01) : num01[33:0];
    n12m   = num12[34] ? 34'(-num12) : num12[33:0];
    n012m  = num012[62] ? 62'(-num012) : num012[61:0];
    d01m   = den01[33] ? 33'(-den01) : den01[32:0];
    d12m   = den12[33] ? 33'(-den12) : den12[32:0];
    d02m   = den02[33] ? 33'(-den02) : den02[32:0];
  end

  assign sts.zero_den = (freq_newer == freq_older) || (w_r == freq_newer)
                        || (w_r == freq_older);

  // divider operand selection
  logic [gdfp_pkg::DIV_W-1:0] dvd;
  logic [6:0]                 nb;
  logic [gdfp_pkg::DEN_W-1:0] dvs;
  logic                       dneg;
  always_comb begin
    case (cmd.div_sel)
      gdfp_pkg::DIV_F01: begin
        dvd = {n01m, 52'd0};  nb = 7'd60; dvs = d01m;
        dneg = num01[34] ^ den01[33];
      end
      gdfp_pkg::DIV_F12: begin
        dvd = {n12m, 52'd0};  nb = 7'd60; dvs = d12m;
        dneg = num12[34] ^ den12[33];
      end
      gdfp_pkg::DIV_F012: begin
        dvd = {n012m, 24'd0}; nb = 7'd86; dvs = d02m;
        dneg = num012[62] ^ den02[33];
      end
      default: begin
        dvd = {gdfp_pkg::FREQ_NUM, 46'd0}; nb = 7'd40; dvs = {13'd0, wl_r};
        dneg = 1'b0;
      end
    endcase
  end

  logic                       div_done;
  logic [gdfp_pkg::DIV_W-1:0] quot;
  logic                       rnd;

  gdfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .nbits    (nb),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot),
    .round_up (rnd)
  );

  // rounded, saturated quotient
  logic [60:0]        fmag;
  logic signed [61:0] fval;
  logic [32:0]        wsum;
  logic [31:0]        w_new;
  always_comb begin
    fmag  = (quot[85:60] != '0) ? gdfp_pkg::SAT_MAG : {1'b0, quot[59:0]} + 61'(rnd);
    fval  = dneg ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
    wsum  = {1'b0, quot[31:0]} + 33'(rnd);
    w_new = ((quot[85:32] != '0) || wsum[32]) ? 32'hFFFFFFFF : wsum[31:0];
  end

  // multiplier operands: f012 by 2w - x0 - x1 for the selected point
  logic [31:0]        xp;
  logic signed [34:0] mval;
  logic [33:0]        mmag;
  logic [61:0]        amag;
  always_comb begin
    case (cmd.pt)
      2'd0:    xp = freq_older;
      2'd1:    xp = freq_newer;
      default: xp = w_r;
    endcase
    mval = $signed({2'b00, xp, 1'b0}) - $signed({3'b000, freq_older})
           - $signed({3'b000, freq_newer});
    mmag = mval[34] ? 34'(-mval) : mval[33:0];
    amag = f012[61] ? 62'(-f012) : f012;
  end

  logic        mul_done;
  logic [97:0] prod;

  gdfp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (amag[60:0]),
    .b     (mmag),
    .done  (mul_done),
    .prod  (prod)
  );

  // Q.24 rounding of the product, saturated
  logic [97:0] pr;
  logic [73:0] prs;
  logic [60:0] tmag;
  always_comb begin
    pr   = prod + 98'd8388608;
    prs  = pr[97:24];
    tmag = (prs > 74'(gdfp_pkg::SAT_MAG)) ? gdfp_pkg::SAT_MAG : prs[60:0];
  end

  // point and window registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      wl_r   <= wavelength;
      ph_r   <= phase_in;
      last_r <= last_point;
    end
    if (cmd.setup) begin
      y0 <= y0s;
      y1 <= y1u;
      y2 <= y2u;
    end
    if (div_done) begin
      case (cmd.div_sel)
        gdfp_pkg::DIV_F01:  f01  <= fval;
        gdfp_pkg::DIV_F12:  f12  <= fval;
        gdfp_pkg::DIV_F012: f012 <= fval;
        default:            w_r  <= w_new;
      endcase
    end
    if (cmd.mul_start) mul_neg <= f012[61] ^ mval[34];
    if (mul_done) t_r <= mul_neg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
  end

  // history of the last two points
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_older  <= '0;
      freq_newer  <= '0;
      phase_older <= '0;
      phase_newer <= '0;
    end else if (cmd.update) begin
      freq_older  <= freq_newer;
      freq_newer  <= w_r;
      phase_older <= phase_newer;
      phase_newer <= ph_r;
    end
  end

  // result value
  logic signed [62:0] gd_v, gdd_v;
  logic [31:0]        q16;
  always_comb begin
    gd_v  = -($signed({f01[61], f01}) + $signed({t_r[61], t_r}));
    gdd_v = -$signed({f012, 1'b0});
    q16   = to_q16(kind_r ? gdd_v : gd_v);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tlast <= cmd.emit_eor;
      if (cmd.emit_short) begin
        m_tdata <= '0;
        m_tuser <= gdfp_pkg::STATUS_SHORT;
      end else if (sts.zero_den) begin
        m_tdata <= '0;
        m_tuser <= gdfp_pkg::STATUS_ZERO_DEN;
      end else begin
        m_tdata <= q16;
        m_tuser <= gdfp_pkg::STATUS_OK;
      end
    end
  end

  assign sts.div_done    = div_done;
  assign sts.mul_done    = mul_done;
  assign sts.out_free    = ~m_tvalid | m_tready;
  assign sts.last_pt     = last_r;
  assign sts.output_kind = kind_r;

endmodule

### rtl/core/gdfp_ctrl.sv
// gdfp_ctrl: sequencer for one point - frequency division, window setup,
// three divided differences, per-result multiply and emit. depends on gdfp_pkg.
`timescale 1ns / 1ps

module gdfp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  gdfp_pkg::sts_t sts,
  output gdfp_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DIV_GO   = 8'b0000_0010,
    ST_DIV_WAIT = 8'b0000_0100,
    ST_SETUP    = 8'b0000_1000,
    ST_MUL_GO   = 8'b0001_0000,
    ST_MUL_WAIT = 8'b0010_0000,
    ST_EMIT     = 8'b0100_0000,
    ST_UPDATE   = 8'b1000_0000
  } state_t;

  state_t             state, state_next;
  logic [1:0]         ps, ps_next;
  gdfp_pkg::div_sel_t div_sel, div_sel_next;
  logic [1:0]         pt, pt_next;
  logic [1:0]         pt_end, pt_end_next;
  logic               short_r, short_next;
  logic               need_mul;

  assign need_mul = ~sts.output_kind & ~sts.zero_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ps      <= '0;
      div_sel <= gdfp_pkg::DIV_FREQ;
      pt      <= '0;
      pt_end  <= '0;
      short_r <= 1'b0;
    end else begin
      state   <= state_next;
      ps      <= ps_next;
      div_sel <= div_sel_next;
      pt      <= pt_next;
      pt_end  <= pt_end_next;
      short_r <= short_next;
    end
  end

  // next state
  always_comb begin
    state_next   = state;
    ps_next      = ps;
    div_sel_next = div_sel;
    pt_next      = pt;
    pt_end_next  = pt_end;
    short_next   = short_r;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          div_sel_next = gdfp_pkg::DIV_FREQ;
          state_next   = ST_DIV_GO;
        end
      end
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          case (div_sel)
            gdfp_pkg::DIV_FREQ: begin
              if (!ps[1]) begin
                if (sts.last_pt) begin
                  short_next  = 1'b1;
                  pt_next     = 2'd0;
                  pt_end_next = ps;
                  state_next  = ST_EMIT;
                end else begin
                  state_next = ST_UPDATE;
                end
              end else begin
                state_next = ST_SETUP;
              end
            end
            gdfp_pkg::DIV_F01: begin
              div_sel_next = gdfp_pkg::DIV_F12;
              state_next   = ST_DIV_GO;
            end
            gdfp_pkg::DIV_F12: begin
              div_sel_next = gdfp_pkg::DIV_F012;
              state_next   = ST_DIV_GO;
            end
            default: begin
              short_next  = 1'b0;
              pt_next     = (ps == 2'd2) ? 2'd0 : 2'd1;
              pt_end_next = sts.last_pt ? 2'd2 : 2'd1;
              state_next  = need_mul ? ST_MUL_GO : ST_EMIT;
            end
          endcase
        end
      end
      ST_SETUP: begin
        if (sts.zero_den) begin
          short_next  = 1'b0;
          pt_next     = (ps == 2'd2) ? 2'd0 : 2'd1;
          pt_end_next = sts.last_pt ? 2'd2 : 2'd1;
          state_next  = ST_EMIT;
        end else begin
          div_sel_next = gdfp_pkg::DIV_F01;
          state_next   = ST_DIV_GO;
        end
      end
      ST_MUL_GO: state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (sts.mul_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          if (pt == pt_end) begin
            state_next = ST_UPDATE;
          end else begin
            pt_next    = pt + 2'd1;
            state_next = (!short_r && need_mul) ? ST_MUL_GO : ST_EMIT;
          end
        end
      end
      ST_UPDATE: begin
        if (sts.last_pt)       ps_next = 2'd0;
        else if (ps != 2'd3)   ps_next = ps + 2'd1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  assign s_tready       = (state == ST_IDLE);
  assign cmd.load_in    = (state == ST_IDLE) & s_tvalid;
  assign cmd.div_start  = (state == ST_DIV_GO);
  assign cmd.div_sel    = div_sel;
  assign cmd.setup      = (state == ST_SETUP);
  assign cmd.mul_start  = (state == ST_MUL_GO);
  assign cmd.pt         = pt;
  assign cmd.emit       = (state == ST_EMIT) & sts.out_free;
  assign cmd.emit_short = short_r;
  assign cmd.emit_eor   = short_r ? (pt == pt_end) : (pt == 2'd2);
  assign cmd.update     = (state == ST_UPDATE);

endmodule

### rtl/core/group_delay_from_phase_top.sv
// group_delay_from_phase_top: top level, joins controller and datapath.
// depends on gdfp_pkg, gdfp_ctrl, gdfp_dp.
//
// Usage
//   s_* channel: one spectrum point per transaction; tlast marks the final
//   point. m_* channel: one result per transaction (value in tdata, status
//   in tuser, tlast on the final result of a spectrum). cfg_*: register
//   writes (0 output kind, 1 unwrap enable), to be written only while idle.
//   The third point of a spectrum yields results for points 0 and 1, each
//   later point the result for its predecessor, and a final point adds its
//   own result. A final point arriving as point 0 or 1 gives short results.
//   One point is worked at a time. Each point takes a frequency reciprocal
//   (40 quotient bits in the shared bit-serial divider); a fitted window
//   adds a setup state and 3 divisions of 60, 60 and 86 bits, plus a
//   multiply per result on the 4-step multiplier in group delay mode and
//   an emit per result. Reset returns the block to the first point of a
//   spectrum with output kind group delay and unwrapping on. A stalled
//   receiver holds the result in the output register; the block keeps
//   working and waits only when it has the next result ready.
`timescale 1ns / 1ps

module group_delay_from_phase_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // [19:0] wavelength, [51:20] phase_in, [55:52] zero
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);

  gdfp_pkg::cmd_t cmd;
  gdfp_pkg::sts_t sts;

  gdfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gdfp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wavelength (s_tdata[19:0]),
    .phase_in   (s_tdata[51:20]),
    .last_point (s_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

### rtl/core/gdfp_chk.sv
// gdfp_chk: port-level checks on the group delay block, bound to the top.
// depends on gdfp_pkg and group_delay_from_phase_top.
`timescale 1ns / 1ps

module gdfp_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == gdfp_pkg::STATUS_OK || m_tuser == gdfp_pkg::STATUS_SHORT
                  || m_tuser == gdfp_pkg::STATUS_ZERO_DEN))
    else $error("undefined status code");

  // an error result carries a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != gdfp_pkg::STATUS_OK |-> m_tdata == 32'd0)
    else $error("error result with non-zero value");

  // one point in work at a time
  a_one_point: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("point accepted while busy");

endmodule

bind group_delay_from_phase_top gdfp_chk u_gdfp_chk (.*);
